### rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/pxcs_pkg.sv
package pxcs_pkg;

    localparam int ARRAY_DEPTH_DEF = 256;
    localparam int BLOCK_SIZE_DEF  = 16;
    localparam int VALUE_BITS_DEF  = 8;

    localparam int POS_W   = 8;
    localparam int VAL_W   = 8;
    localparam int LEN_W   = 9;
    localparam int COUNT_W = 9;

    localparam logic ACT_SET   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic             action;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] operand_value;
    } request_t;

    typedef struct packed {
        logic [COUNT_W-1:0] match_count;
        logic               out_of_range;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_UPD_PRIME,
        ST_UPD_RD,
        ST_UPD_HDEC,
        ST_UPD_HINC,
        ST_UPD_WR,
        ST_Q_BLK_RD,
        ST_Q_BLK_ACC,
        ST_Q_EL_RD,
        ST_Q_EL_ACC,
        ST_DONE
    } state_t;

endpackage

### rtl/core/pxcs_ram.sv
module pxcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/prefix_xor_count_store_top.sv
// Prefix-XOR match counter. A set request (action 0) writes one element and
// rewalks its block from that element to the block end. The running XOR just
// before the element is fetched first, then each element goes through the
// read, old-bin decrement, new-bin increment and write states; it gives no
// result. A query request (action 1) walks every earlier block's histogram and
// total, then the elements of its own block up to the position, and puts one
// result on match_count/out_of_range with done high for one cycle. An
// out-of-range query goes straight to the result, busy only while done is
// high; an out-of-range set is dropped without going busy. The receiver cannot
// stall the result. busy stays high while a request is in work. After reset
// all memories are cleared one entry a cycle, over the larger of
// NUM_BLOCKS * 2**VALUE_BITS and ARRAY_DEPTH addresses (4096 by default),
// with busy high; only each block's histogram bin 0 is set to its length.
`include "assert_macros.svh"

module prefix_xor_count_store_top #(
    parameter int ARRAY_DEPTH = pxcs_pkg::ARRAY_DEPTH_DEF,
    parameter int BLOCK_SIZE  = pxcs_pkg::BLOCK_SIZE_DEF,
    parameter int VALUE_BITS  = pxcs_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  pxcs_pkg::request_t           request,
    output logic                         done,
    output pxcs_pkg::result_t            result,
    input  logic                         cfg_we,
    input  logic [pxcs_pkg::LEN_W-1:0]   cfg_wdata
);

    localparam int NUM_BLOCKS = (ARRAY_DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int AW   = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
    localparam int BW   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int HD   = NUM_BLOCKS * (2 ** VALUE_BITS);
    localparam int HW   = $clog2(HD);
    localparam int CW   = $clog2(BLOCK_SIZE + 1);
    localparam int PW   = AW + 1;
    localparam int LAST_LEN = ARRAY_DEPTH - (NUM_BLOCKS - 1) * BLOCK_SIZE;
    localparam int CLR_N = (HD > ARRAY_DEPTH) ? HD : ARRAY_DEPTH;
    localparam int CLW  = $clog2(CLR_N);

    logic [pxcs_pkg::LEN_W-1:0] len_reg;
    pxcs_pkg::state_t state_reg, state_next;
    logic                 act_reg;
    logic [PW-1:0]        pos_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] key_reg;
    logic                 key_bad_reg;
    logic [PW-1:0]        j_reg;
    logic [PW-1:0]        end_reg;
    logic [BW-1:0]        blk_reg;
    logic [VALUE_BITS-1:0] x_reg;
    logic [VALUE_BITS-1:0] old_rx_reg;
    logic [pxcs_pkg::COUNT_W-1:0] count_reg;
    logic [CLW:0]         clr_reg;
    logic                 oor_reg;

    // memories
    logic               el_we, rx_we, tot_we, h_we;
    logic [AW-1:0]      el_waddr, el_raddr, rx_waddr, rx_raddr;
    logic [VALUE_BITS-1:0] el_wdata, el_rdata, rx_wdata, rx_rdata;
    logic [BW-1:0]      tot_waddr, tot_raddr;
    logic [VALUE_BITS-1:0] tot_wdata, tot_rdata;
    logic [HW-1:0]      h_waddr, h_raddr;
    logic [CW-1:0]      h_wdata, h_rdata;

    pxcs_ram #(.WIDTH(VALUE_BITS), .DEPTH(ARRAY_DEPTH)) u_el (
        .clk(clk), .we(el_we), .waddr(el_waddr), .wdata(el_wdata),
        .raddr(el_raddr), .rdata(el_rdata));
    pxcs_ram #(.WIDTH(VALUE_BITS), .DEPTH(ARRAY_DEPTH)) u_rx (
        .clk(clk), .we(rx_we), .waddr(rx_waddr), .wdata(rx_wdata),
        .raddr(rx_raddr), .rdata(rx_rdata));
    pxcs_ram #(.WIDTH(VALUE_BITS), .DEPTH(NUM_BLOCKS)) u_tot (
        .clk(clk), .we(tot_we), .waddr(tot_waddr), .wdata(tot_wdata),
        .raddr(tot_raddr), .rdata(tot_rdata));
    pxcs_ram #(.WIDTH(CW), .DEPTH(HD)) u_hist (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata));

    logic              accept;
    logic              addressable;
    logic [PW-1:0]     in_pos;
    logic [BW-1:0]     in_blk;
    logic [PW-1:0]     blk_start;
    logic [PW-1:0]     blk_end;
    logic [VALUE_BITS-1:0] nx;
    logic [BW-1:0]     clr_blk;

    assign accept = start && !busy;
    assign in_pos = PW'(request.position);
    assign addressable = (9'(request.position) < len_reg)
        && (32'(request.position) < 32'(ARRAY_DEPTH));
    assign in_blk = BW'(32'(request.position) / BLOCK_SIZE);
    assign blk_start = PW'(32'(in_blk) * BLOCK_SIZE);
    assign blk_end = ((32'(in_blk) + 1) * BLOCK_SIZE > ARRAY_DEPTH) ?
        PW'(ARRAY_DEPTH) : PW'((32'(in_blk) + 1) * BLOCK_SIZE);
    assign nx = x_reg ^ ((j_reg == pos_reg) ? val_reg : el_rdata);
    assign clr_blk = BW'(clr_reg[HW-1:0] >> VALUE_BITS);

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= pxcs_pkg::LEN_W'(256);
        end
        else if (cfg_we)
        begin
            len_reg <= cfg_wdata;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pxcs_pkg::ST_CLEAR:
            begin
                if (clr_reg == (CLW+1)'(CLR_N - 1))
                begin
                    state_next = pxcs_pkg::ST_IDLE;
                end
            end
            pxcs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (!addressable)
                    begin
                        state_next = request.action ? pxcs_pkg::ST_DONE : pxcs_pkg::ST_IDLE;
                    end
                    else if (request.action == pxcs_pkg::ACT_SET)
                    begin
                        state_next = pxcs_pkg::ST_UPD_PRIME;
                    end
                    else if (in_blk != '0)
                    begin
                        state_next = pxcs_pkg::ST_Q_BLK_RD;
                    end
                    else
                    begin
                        state_next = pxcs_pkg::ST_Q_EL_RD;
                    end
                end
            end
            pxcs_pkg::ST_UPD_PRIME: state_next = pxcs_pkg::ST_UPD_RD;
            pxcs_pkg::ST_UPD_RD:   state_next = pxcs_pkg::ST_UPD_HDEC;
            pxcs_pkg::ST_UPD_HDEC: state_next = pxcs_pkg::ST_UPD_HINC;
            pxcs_pkg::ST_UPD_HINC: state_next = pxcs_pkg::ST_UPD_WR;
            pxcs_pkg::ST_UPD_WR:
            begin
                state_next = (j_reg + 1'b1 == end_reg) ? pxcs_pkg::ST_IDLE
                                                        : pxcs_pkg::ST_UPD_RD;
            end
            pxcs_pkg::ST_Q_BLK_RD:  state_next = pxcs_pkg::ST_Q_BLK_ACC;
            pxcs_pkg::ST_Q_BLK_ACC:
            begin
                state_next = (32'(j_reg) + 1 == 32'(blk_reg)) ? pxcs_pkg::ST_Q_EL_RD
                                                             : pxcs_pkg::ST_Q_BLK_RD;
            end
            pxcs_pkg::ST_Q_EL_RD:  state_next = pxcs_pkg::ST_Q_EL_ACC;
            pxcs_pkg::ST_Q_EL_ACC:
            begin
                state_next = (j_reg == pos_reg) ? pxcs_pkg::ST_DONE
                                                : pxcs_pkg::ST_Q_EL_RD;
            end
            pxcs_pkg::ST_DONE:     state_next = pxcs_pkg::ST_IDLE;
            default:               state_next = pxcs_pkg::ST_IDLE;
        endcase
    end

    // memory controls and outputs
    always_comb
    begin
        busy = (state_reg != pxcs_pkg::ST_IDLE);
        done = (state_reg == pxcs_pkg::ST_DONE);
        result.match_count = count_reg;
        result.out_of_range = oor_reg;
        el_we = 1'b0; el_waddr = j_reg[AW-1:0]; el_wdata = val_reg;
        el_raddr = j_reg[AW-1:0];
        rx_we = 1'b0; rx_waddr = j_reg[AW-1:0]; rx_wdata = nx;
        rx_raddr = j_reg[AW-1:0];
        tot_we = 1'b0; tot_waddr = blk_reg; tot_wdata = nx;
        tot_raddr = j_reg[BW-1:0];
        h_we = 1'b0; h_waddr = {blk_reg, old_rx_reg}; h_wdata = '0;
        h_raddr = {blk_reg, old_rx_reg};
        case (state_reg)
            pxcs_pkg::ST_CLEAR:
            begin
                h_we = (32'(clr_reg) < HD);
                h_waddr = clr_reg[HW-1:0];
                if (clr_reg[VALUE_BITS-1:0] == '0)
                begin
                    h_wdata = (32'(clr_blk) == NUM_BLOCKS - 1) ? CW'(LAST_LEN)
                                                               : CW'(BLOCK_SIZE);
                end
                el_we = (32'(clr_reg) < ARRAY_DEPTH);
                el_waddr = clr_reg[AW-1:0];
                el_wdata = '0;
                rx_we = (32'(clr_reg) < ARRAY_DEPTH);
                rx_waddr = clr_reg[AW-1:0];
                rx_wdata = '0;
                tot_we = (32'(clr_reg) < NUM_BLOCKS);
                tot_waddr = clr_reg[BW-1:0];
                tot_wdata = '0;
            end
            pxcs_pkg::ST_IDLE:
            begin
                // fetch the running XOR just before the requested position
                rx_raddr = in_pos[AW-1:0] - 1'b1;
            end
            pxcs_pkg::ST_UPD_HDEC:
            begin
                // old running XOR arrives now; read its bin
                h_raddr = {blk_reg, rx_rdata};
            end
            pxcs_pkg::ST_UPD_HINC:
            begin
                h_we = 1'b1;
                h_waddr = {blk_reg, old_rx_reg};
                h_wdata = h_rdata - 1'b1;
                h_raddr = {blk_reg, x_reg};
            end
            pxcs_pkg::ST_UPD_WR:
            begin
                h_we = 1'b1;
                h_waddr = {blk_reg, x_reg};
                // forward the decrement when old and new bin coincide
                h_wdata = (old_rx_reg == x_reg) ? h_rdata : h_rdata + 1'b1;
                rx_we = 1'b1;
                rx_wdata = x_reg;
                el_we = (j_reg == pos_reg);
                tot_we = (j_reg + 1'b1 == end_reg);
                tot_wdata = x_reg;
            end
            pxcs_pkg::ST_Q_BLK_RD:
            begin
                h_raddr = {j_reg[BW-1:0], key_reg ^ x_reg};
            end
            default:
            begin
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pxcs_pkg::ST_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
            oor_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                pxcs_pkg::ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
                pxcs_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        act_reg     <= request.action;
                        pos_reg     <= in_pos;
                        val_reg     <= VALUE_BITS'(request.operand_value);
                        key_reg     <= VALUE_BITS'(request.operand_value);
                        key_bad_reg <= (32'(request.operand_value) >> VALUE_BITS) != 0;
                        blk_reg     <= in_blk;
                        end_reg     <= blk_end;
                        x_reg       <= '0;
                        count_reg   <= '0;
                        oor_reg     <= !addressable;
                        j_reg       <= (request.action == pxcs_pkg::ACT_SET) ? in_pos
                                       : ((in_blk != '0) ? '0 : blk_start);
                    end
                end
                pxcs_pkg::ST_UPD_PRIME:
                begin
                    // seed x from the previous running XOR unless at block start
                    if (pos_reg != PW'(32'(blk_reg) * BLOCK_SIZE))
                    begin
                        x_reg <= rx_rdata;
                    end
                end
                pxcs_pkg::ST_UPD_HDEC:
                begin
                    old_rx_reg <= rx_rdata;
                    x_reg      <= nx;
                end
                pxcs_pkg::ST_UPD_WR:
                begin
                    j_reg <= j_reg + 1'b1;
                end
                pxcs_pkg::ST_Q_BLK_ACC:
                begin
                    if (!key_bad_reg)
                    begin
                        count_reg <= count_reg + pxcs_pkg::COUNT_W'(h_rdata);
                    end
                    x_reg <= x_reg ^ tot_rdata;
                    j_reg <= (32'(j_reg) + 1 == 32'(blk_reg))
                        ? PW'(32'(blk_reg) * BLOCK_SIZE) : j_reg + 1'b1;
                end
                pxcs_pkg::ST_Q_EL_ACC:
                begin
                    if (!key_bad_reg && ((x_reg ^ rx_rdata) == key_reg))
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    j_reg <= j_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    `ASSERT_IMPLY(a_done_query, clk, rst_n, done, act_reg == pxcs_pkg::ACT_QUERY)
    `ASSERT_NEXT(a_start_busy, clk, rst_n, accept && request.action, busy)
    `ASSERT_IMPLY(a_oor_zero, clk, rst_n, done && result.out_of_range,
        result.match_count == '0)
    `ASSERT_IMPLY(a_no_write_query, clk, rst_n, act_reg == pxcs_pkg::ACT_QUERY && busy
        && state_reg != pxcs_pkg::ST_CLEAR, !h_we)

endmodule
